/* sv/fssa_pkg.sv */
// Shared types, constants and command/status structs of the fixed-slot allocator.
`default_nettype none

package fssa_pkg;

    localparam int MAX_SLOTS = 4096;
    localparam int IDX_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = IDX_W + 1;
    localparam int ADDR_W    = 32;
    localparam int REGION_W  = 25;
    localparam int SLOT_W    = 17;
    localparam int RSIZE_W   = 24;
    localparam int DVD_W     = REGION_W;
    localparam int DCNT_W    = $clog2(DVD_W);

    localparam logic [ADDR_W-1:0] HEADER_BYTES = 32'd16;

    localparam logic [1:0] CFG_BASE   = 2'd0;
    localparam logic [1:0] CFG_REGION = 2'd1;
    localparam logic [1:0] CFG_SLOT   = 2'd2;

    localparam logic [ADDR_W-1:0]   RST_BASE   = 32'h0020_0000;
    localparam logic [REGION_W-1:0] RST_REGION = 25'd1048576;
    localparam logic [SLOT_W-1:0]   RST_SLOT   = 17'd16;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_INIT  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_BIG   = 3'd1,
        ST_NO_SLOTS  = 3'd2,
        ST_OUTSIDE   = 3'd3,
        ST_UNDERFLOW = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_ALLOC,
        S_DIV1,
        S_DIV2_GO,
        S_DIV2,
        S_MUL,
        S_FILL,
        S_OUT
    } t_state;

    typedef struct packed {
        logic    load_req;
        logic    set_status;
        t_status status;
        logic    mem_rd;
        logic    grant;
        logic    push;
        logic    init_zero;
        logic    div1_start;
        logic    cnt_load;
        logic    div2_start;
        logic    rsv_load;
        logic    mul;
        logic    fill;
        logic    emit;
    } t_cmd;

    typedef struct packed {
        t_req req_type;
        logic too_big;
        logic no_slots;
        logic outside;
        logic underflow;
        logic init_zero;
        logic div_done;
        logic fill_done;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

/* sv/fixed_slot_stack_allocator_top.sv */
// Fixed-slot allocator: a stack of free slot offsets over one memory region.
//
// Requests enter on the s_axis channel, one at a time; tuser carries the request
// kind (allocate, free, init) and tdata the request size and free address.
// Each request yields exactly one result transfer on m_axis: granted address and
// status. The configuration port writes base address, region size and slot size
// and must be used only while no request is in flight; the block itself does not
// enforce it. A free request, a failed allocate and any other request that does
// no division go from decode straight to output; a granted allocate first reads
// the offset stack memory, then adds the address. An init request runs two
// divisions (slot count, reserved slots), a multiply, then writes one stack entry
// per cycle for every slot above the reserved ones. A new request is taken only
// once the result of the last one has been loaded into the output register.
// s_axis_tready is high only while the controller is idle.
// The result sits in an output register, so a new request is taken while a result
// still waits; the block holds in its last state until m_axis_tready frees it.
// Reset clears stack top and slot count and restores the register defaults; the
// stack memory itself is not cleared and is filled by the next init.
`default_nettype none

module fixed_slot_stack_allocator_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [23:0] request_size, [55:24] free_address
    input  wire logic [55:0] s_axis_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [31:0] granted_address, [34:32] status, [39:35] zero
    output logic [39:0]      m_axis_tdata
);

    fssa_pkg::t_cmd cmd;
    fssa_pkg::t_sts sts;
    logic [31:0]    granted;
    logic [2:0]     status;

    fssa_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .i_sts     (sts),
        .o_s_ready (s_axis_tready),
        .o_cmd     (cmd)
    );

    fssa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_req_type     (s_axis_tuser),
        .i_request_size (s_axis_tdata[23:0]),
        .i_free_address (s_axis_tdata[55:24]),
        .i_m_ready      (m_axis_tready),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .o_m_valid      (m_axis_tvalid),
        .o_granted      (granted),
        .o_status       (status)
    );

    assign m_axis_tdata = {5'd0, status, granted};

endmodule

`default_nettype wire

/* sv/fssa_div.sv */
// Restoring divider, one quotient bit per cycle, used for the slot and reserve counts.
`default_nettype none

module fssa_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [fssa_pkg::DVD_W-1:0]  i_dividend,
    input  wire logic [fssa_pkg::SLOT_W-1:0] i_divisor,
    output logic                             o_done,
    output logic [fssa_pkg::DVD_W-1:0]       o_quotient
);

    logic                          r_busy;
    logic                          r_done;
    logic [fssa_pkg::DCNT_W-1:0]   r_cnt;
    logic [fssa_pkg::SLOT_W-1:0]   r_rem;
    logic [fssa_pkg::DVD_W-1:0]    r_quo;
    logic [fssa_pkg::SLOT_W:0]     shifted;
    logic [fssa_pkg::SLOT_W:0]     diff;
    logic                          ge;
    logic [fssa_pkg::SLOT_W-1:0]   n_rem;

    assign shifted = {r_rem, r_quo[fssa_pkg::DVD_W-1]};
    assign ge      = shifted >= {1'b0, i_divisor};
    assign diff    = shifted - {1'b0, i_divisor};
    assign n_rem   = ge ? diff[fssa_pkg::SLOT_W-1:0] : shifted[fssa_pkg::SLOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == fssa_pkg::DCNT_W'(fssa_pkg::DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[fssa_pkg::DVD_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

/* sv/fssa_dp.sv */
// Datapath: configuration registers, free-offset stack memory, counters and result register.
`default_nettype none

module fssa_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [1:0]                     i_cfg_addr,
    input  wire logic [31:0]                    i_cfg_wdata,
    input  wire logic [1:0]                     i_req_type,
    input  wire logic [fssa_pkg::RSIZE_W-1:0]   i_request_size,
    input  wire logic [fssa_pkg::ADDR_W-1:0]    i_free_address,
    input  wire logic                           i_m_ready,
    input  wire fssa_pkg::t_cmd                 i_cmd,
    output fssa_pkg::t_sts                      o_sts,
    output logic                                o_m_valid,
    output logic [fssa_pkg::ADDR_W-1:0]         o_granted,
    output logic [2:0]                          o_status
);

    logic [fssa_pkg::ADDR_W-1:0]   r_base;
    logic [fssa_pkg::REGION_W-1:0] r_region;
    logic [fssa_pkg::SLOT_W-1:0]   r_slot;

    fssa_pkg::t_req                r_req;
    logic [fssa_pkg::RSIZE_W-1:0]  r_size;
    logic [fssa_pkg::ADDR_W-1:0]   r_addr;

    logic [fssa_pkg::CNT_W-1:0]    r_top;
    logic [fssa_pkg::CNT_W-1:0]    r_count;
    logic [fssa_pkg::CNT_W-1:0]    r_x;
    logic [fssa_pkg::ADDR_W-1:0]   r_off;

    logic [fssa_pkg::ADDR_W-1:0]   r_mem [fssa_pkg::MAX_SLOTS];
    logic [fssa_pkg::ADDR_W-1:0]   r_rdata;

    logic [fssa_pkg::ADDR_W-1:0]   r_granted;
    fssa_pkg::t_status             r_status;
    logic                          r_m_valid;
    logic [fssa_pkg::ADDR_W-1:0]   r_m_granted;
    logic [2:0]                    r_m_status;

    logic [fssa_pkg::ADDR_W-1:0]   first;
    logic [fssa_pkg::ADDR_W:0]     region_end;
    logic [fssa_pkg::CNT_W-1:0]    top_dec;
    logic                          div_start;
    logic [fssa_pkg::DVD_W-1:0]    dividend;
    logic [fssa_pkg::DVD_W-1:0]    quotient;
    logic                          div_done;
    logic [fssa_pkg::SLOT_W+1:0]   rsv_dvd;
    logic                          mem_we;
    logic [fssa_pkg::IDX_W-1:0]    mem_waddr;
    logic [fssa_pkg::ADDR_W-1:0]   mem_wdata;

    assign first      = r_base + fssa_pkg::HEADER_BYTES;
    assign region_end = {1'b0, r_base} + {8'd0, r_region};
    assign top_dec    = r_top - 1'b1;

    // Reserve count dividend: count*4 + slot_size - 1, for a rounded-up quotient.
    assign rsv_dvd  = {4'd0, r_count, 2'b00} + {2'b00, r_slot} - 1'b1;
    assign div_start = i_cmd.div1_start | i_cmd.div2_start;
    assign dividend  = i_cmd.div1_start ? (r_region - fssa_pkg::REGION_W'(16))
                                        : fssa_pkg::DVD_W'(rsv_dvd);

    fssa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (dividend),
        .i_divisor  (r_slot),
        .o_done     (div_done),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= fssa_pkg::RST_BASE;
            r_region <= fssa_pkg::RST_REGION;
            r_slot   <= fssa_pkg::RST_SLOT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                fssa_pkg::CFG_BASE:   r_base   <= i_cfg_wdata;
                fssa_pkg::CFG_REGION: r_region <= i_cfg_wdata[fssa_pkg::REGION_W-1:0];
                fssa_pkg::CFG_SLOT:   r_slot   <= i_cfg_wdata[fssa_pkg::SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req  <= fssa_pkg::t_req'(i_req_type);
            r_size <= i_request_size;
            r_addr <= i_free_address;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= '0;
            r_count <= '0;
        end else if (i_cmd.grant) begin
            r_top <= r_top + 1'b1;
        end else if (i_cmd.push) begin
            r_top <= top_dec;
        end else if (i_cmd.init_zero) begin
            r_top   <= '0;
            r_count <= '0;
        end else if (i_cmd.cnt_load) begin
            r_top <= '0;
            if (quotient > fssa_pkg::DVD_W'(fssa_pkg::MAX_SLOTS)) begin
                r_count <= fssa_pkg::CNT_W'(fssa_pkg::MAX_SLOTS);
            end else begin
                r_count <= quotient[fssa_pkg::CNT_W-1:0];
            end
        end else if (i_cmd.rsv_load) begin
            if (quotient > fssa_pkg::DVD_W'(r_count)) begin
                r_top <= r_count;
            end else begin
                r_top <= quotient[fssa_pkg::CNT_W-1:0];
            end
        end
    end

    // Fill cursor and its slot offset walk up together during an init.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rsv_load) begin
            if (quotient > fssa_pkg::DVD_W'(r_count)) begin
                r_x <= r_count;
            end else begin
                r_x <= quotient[fssa_pkg::CNT_W-1:0];
            end
        end else if (i_cmd.mul) begin
            r_off <= fssa_pkg::ADDR_W'(r_x * r_slot);
        end else if (i_cmd.fill) begin
            r_x   <= r_x + 1'b1;
            r_off <= r_off + fssa_pkg::ADDR_W'(r_slot);
        end
    end

    assign mem_we    = i_cmd.push | i_cmd.fill;
    assign mem_waddr = i_cmd.push ? top_dec[fssa_pkg::IDX_W-1:0] : r_x[fssa_pkg::IDX_W-1:0];
    assign mem_wdata = i_cmd.push ? (r_addr - first) : r_off;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_rd) begin
            r_rdata <= r_mem[r_top[fssa_pkg::IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.grant) begin
            r_granted <= first + r_rdata;
            r_status  <= fssa_pkg::ST_OK;
        end else if (i_cmd.set_status) begin
            r_granted <= '0;
            r_status  <= i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_m_granted <= r_granted;
            r_m_status  <= r_status;
        end
    end

    always_comb begin
        o_sts.req_type  = r_req;
        o_sts.too_big   = r_size > fssa_pkg::RSIZE_W'(r_slot);
        o_sts.no_slots  = r_top >= r_count;
        o_sts.outside   = !((r_addr > r_base) && ({1'b0, r_addr} < region_end));
        o_sts.underflow = r_top == '0;
        o_sts.init_zero = (r_slot == '0) || (r_region < fssa_pkg::REGION_W'(16));
        o_sts.div_done  = div_done;
        o_sts.fill_done = r_x >= r_count;
        o_sts.out_free  = !r_m_valid || i_m_ready;
    end

    assign o_m_valid = r_m_valid;
    assign o_granted = r_m_granted;
    assign o_status  = r_m_status;

`ifndef SYNTHESIS
    a_top_le_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_top <= r_count)
        else $error("stack top beyond slot count");

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= fssa_pkg::CNT_W'(fssa_pkg::MAX_SLOTS))
        else $error("slot count above maximum");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill |-> (r_x < r_count))
        else $error("fill write beyond slot count");

    a_read_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mem_rd |-> !o_sts.no_slots && !o_sts.too_big)
        else $error("stack read issued for a failing allocate");
`endif

endmodule

`default_nettype wire

/* sv/fssa_ctrl.sv */
// Controller state machine sequencing allocate, free and init requests.
`default_nettype none

module fssa_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_valid,
    input  wire fssa_pkg::t_sts i_sts,
    output logic                o_s_ready,
    output fssa_pkg::t_cmd      o_cmd
);

    fssa_pkg::t_state r_state;
    fssa_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fssa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fssa_pkg::S_IDLE: begin
                if (i_s_valid) n_state = fssa_pkg::S_DECODE;
            end
            fssa_pkg::S_DECODE: begin
                unique case (i_sts.req_type)
                    fssa_pkg::REQ_ALLOC: begin
                        if (i_sts.too_big || i_sts.no_slots) n_state = fssa_pkg::S_OUT;
                        else n_state = fssa_pkg::S_ALLOC;
                    end
                    fssa_pkg::REQ_INIT: begin
                        if (i_sts.init_zero) n_state = fssa_pkg::S_OUT;
                        else n_state = fssa_pkg::S_DIV1;
                    end
                    default: n_state = fssa_pkg::S_OUT;
                endcase
            end
            fssa_pkg::S_ALLOC:   n_state = fssa_pkg::S_OUT;
            fssa_pkg::S_DIV1: begin
                if (i_sts.div_done) n_state = fssa_pkg::S_DIV2_GO;
            end
            fssa_pkg::S_DIV2_GO: n_state = fssa_pkg::S_DIV2;
            fssa_pkg::S_DIV2: begin
                if (i_sts.div_done) n_state = fssa_pkg::S_MUL;
            end
            fssa_pkg::S_MUL:     n_state = fssa_pkg::S_FILL;
            fssa_pkg::S_FILL: begin
                if (i_sts.fill_done) n_state = fssa_pkg::S_OUT;
            end
            fssa_pkg::S_OUT: begin
                if (i_sts.out_free) n_state = fssa_pkg::S_IDLE;
            end
            default: n_state = fssa_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.status = fssa_pkg::ST_OK;
        o_s_ready    = 1'b0;
        unique case (r_state)
            fssa_pkg::S_IDLE: begin
                o_s_ready      = 1'b1;
                o_cmd.load_req = i_s_valid;
            end
            fssa_pkg::S_DECODE: begin
                o_cmd.set_status = 1'b1;
                unique case (i_sts.req_type)
                    fssa_pkg::REQ_ALLOC: begin
                        if (i_sts.too_big) begin
                            o_cmd.status = fssa_pkg::ST_TOO_BIG;
                        end else if (i_sts.no_slots) begin
                            o_cmd.status = fssa_pkg::ST_NO_SLOTS;
                        end else begin
                            o_cmd.mem_rd = 1'b1;
                        end
                    end
                    fssa_pkg::REQ_FREE: begin
                        if (i_sts.outside) begin
                            o_cmd.status = fssa_pkg::ST_OUTSIDE;
                        end else if (i_sts.underflow) begin
                            o_cmd.status = fssa_pkg::ST_UNDERFLOW;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end
                    fssa_pkg::REQ_INIT: begin
                        if (i_sts.init_zero) o_cmd.init_zero = 1'b1;
                        else o_cmd.div1_start = 1'b1;
                    end
                    default: ;
                endcase
            end
            fssa_pkg::S_ALLOC:   o_cmd.grant = 1'b1;
            fssa_pkg::S_DIV1:    o_cmd.cnt_load = i_sts.div_done;
            fssa_pkg::S_DIV2_GO: o_cmd.div2_start = 1'b1;
            fssa_pkg::S_DIV2:    o_cmd.rsv_load = i_sts.div_done;
            fssa_pkg::S_MUL:     o_cmd.mul = 1'b1;
            fssa_pkg::S_FILL:    o_cmd.fill = !i_sts.fill_done;
            fssa_pkg::S_OUT:     o_cmd.emit = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// Self-checking bench for the fixed-slot allocator: a directed table, then random phases.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import fssa_pkg::*;

    localparam int IDLE_LIMIT   = 20000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 700;
    localparam int PRINT_CAP    = 40;

    typedef struct packed {
        logic [31:0] addr;
        t_status     status;
    } t_grant;

    typedef enum bit {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        t_req        req;
        logic [23:0] size;
        logic [31:0] addr;
        bit          typed;
        logic [31:0] want_addr;
        t_status     want_status;
        logic [31:0] base;
        logic [24:0] region;
        logic [16:0] slot;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [31:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;    // [23:0] request_size, [55:24] free_address
    logic [1:0]  s_axis_tuser;    // [1:0] req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;    // [31:0] granted_address, [34:32] status, [39:35] zero

    fixed_slot_stack_allocator_top uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    // Shadow copy of the allocator state and its registers.
    logic [31:0] cur_base;
    logic [24:0] cur_region;
    logic [16:0] cur_slot;
    logic [31:0] offset_stack [MAX_SLOTS];
    int unsigned stack_top;
    int unsigned slot_count;

    logic [31:0] live_blocks [$];
    t_grant      pending_grants [$];
    t_row        stimulus_table [$];

    int mismatches;
    int quiet_cycles;
    int phases;
    int req_tally [4];
    int status_tally [8];
    bit gaps_on;
    bit rx_bursty;
    bit long_hold_ask;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_grant predict_grant(t_req req, logic [23:0] size,
                                             logic [31:0] addr);
        t_grant            g;
        logic [31:0]       first;
        logic [63:0]       region_end;
        longint unsigned   cnt;
        longint unsigned   rsv;
        longint unsigned   x;
        g.addr   = '0;
        g.status = ST_OK;
        first    = cur_base + HEADER_BYTES;
        case (req)
            REQ_ALLOC: begin
                if (size > cur_slot) begin
                    g.status = ST_TOO_BIG;
                end else if (stack_top >= slot_count || stack_top >= MAX_SLOTS) begin
                    g.status = ST_NO_SLOTS;
                end else begin
                    g.addr = first + offset_stack[stack_top];
                    stack_top++;
                    live_blocks.push_back(g.addr);
                end
            end
            REQ_FREE: begin
                // The region test is done on the full sum, so a region that runs
                // past the top of the address space does not wrap.
                region_end = {32'b0, cur_base} + {39'b0, cur_region};
                if (!({32'b0, addr} > {32'b0, cur_base} && {32'b0, addr} < region_end)) begin
                    g.status = ST_OUTSIDE;
                end else if (stack_top == 0) begin
                    g.status = ST_UNDERFLOW;
                end else begin
                    stack_top--;
                    offset_stack[stack_top] = addr - first;
                end
            end
            REQ_INIT: begin
                cnt = 0;
                rsv = 0;
                if (cur_slot != 0 && cur_region >= 16) begin
                    cnt = (cur_region - 16) / cur_slot;
                    if (cnt > MAX_SLOTS) cnt = MAX_SLOTS;
                    rsv = (cnt * 4 + cur_slot - 1) / cur_slot;
                end
                if (rsv > cnt) rsv = cnt;
                for (x = rsv; x < cnt; x++) offset_stack[x] = 32'(x * cur_slot);
                slot_count = int'(cnt);
                stack_top  = int'(rsv);
                live_blocks.delete();
            end
            default: ;
        endcase
        return g;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
    endtask

    // Drives one request at the current falling edge and returns at the falling edge
    // after its transfer. The valid is left high; the caller lowers it when idling.
    task automatic send_request(t_req req, logic [23:0] size, logic [31:0] addr,
                                bit typed, logic [31:0] want_addr, t_status want_status);
        t_grant g;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {addr, size};
        do @(posedge i_clk); while (!s_axis_tready);
        g = predict_grant(req, size, addr);
        if (typed) begin
            g.addr   = want_addr;
            g.status = want_status;
        end
        pending_grants.push_back(g);
        req_tally[req]++;
        @(negedge i_clk);
    endtask

    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        wait (pending_grants.size() == 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic apply_config(logic [31:0] base, logic [24:0] region, logic [16:0] slot);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_BASE;
        i_cfg_wdata <= base;
        @(negedge i_clk);
        i_cfg_addr  <= CFG_REGION;
        i_cfg_wdata <= 32'(region);
        @(negedge i_clk);
        i_cfg_addr  <= CFG_SLOT;
        i_cfg_wdata <= 32'(slot);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_base   = base;
        cur_region = region;
        cur_slot   = slot;
        phases++;
    endtask

    function automatic void add_req(t_req req, logic [23:0] size, logic [31:0] addr,
                                    bit typed, logic [31:0] want_addr, t_status want_status);
        t_row r;
        r.kind        = ROW_REQ;
        r.req         = req;
        r.size        = size;
        r.addr        = addr;
        r.typed       = typed;
        r.want_addr   = want_addr;
        r.want_status = want_status;
        r.base        = '0;
        r.region      = '0;
        r.slot        = '0;
        stimulus_table.push_back(r);
    endfunction

    function automatic void add_cfg(logic [31:0] base, logic [24:0] region, logic [16:0] slot);
        t_row r;
        r.kind        = ROW_CFG;
        r.req         = REQ_NONE;
        r.size        = '0;
        r.addr        = '0;
        r.typed       = 1'b0;
        r.want_addr   = '0;
        r.want_status = ST_OK;
        r.base        = base;
        r.region      = region;
        r.slot        = slot;
        stimulus_table.push_back(r);
    endfunction

    task automatic pick_config(int phase, output logic [31:0] base,
                               output logic [24:0] region, output logic [16:0] slot);
        int mode;
        mode = $urandom_range(0, 99);
        case ($urandom_range(0, 4))
            0:       base = $urandom;
            1:       base = 32'hFFFF_0000 | 32'($urandom_range(0, 65535));
            2:       base = 32'($urandom_range(0, 65535));
            default: base = $urandom;
        endcase
        if (phase == 0) begin
            base   = 32'h0000_0000;
            region = 25'd16777216;
            slot   = 17'd65536;
        end else if (phase == 1) begin
            base   = 32'hFFFF_FFFF;
            region = 25'd256;
            slot   = 17'd8;
        end else if (phase == 2) begin
            base   = 32'hFFFF_FF00;
            region = 25'd17;
            slot   = 17'd4;
        end else if (mode < 70) begin
            slot   = 17'($urandom_range(4, 64));
            region = 25'(17 + $urandom_range(0, 40 * slot));
        end else if (mode < 78) begin
            // Full-size stack: the slot count is clamped to the maximum.
            slot   = 17'($urandom_range(4, 16));
            region = 25'($urandom_range(1048576, 16777216));
        end else if (mode < 90) begin
            slot   = 17'($urandom_range(16384, 65536));
            region = 25'($urandom);
        end else begin
            slot   = 17'($urandom_range(0, 3));
            region = 25'($urandom_range(0, 60));
        end
    endtask

    task automatic random_item();
        t_req        req;
        logic [23:0] size;
        logic [31:0] addr;
        int          pick;
        int          idx;
        pick = $urandom_range(0, 99);
        size = 24'($urandom_range(0, cur_slot));
        if ($urandom_range(0, 9) == 0) size = 24'($urandom);
        addr = $urandom;
        if (pick < 48) begin
            req = REQ_ALLOC;
        end else if (pick < 88) begin
            req  = REQ_FREE;
            pick = $urandom_range(0, 99);
            if (pick < 65 && live_blocks.size() > 0) begin
                idx  = $urandom_range(0, live_blocks.size() - 1);
                addr = live_blocks[idx];
                // Now and then the block stays on the list and gets freed twice.
                if ($urandom_range(0, 9) != 0) live_blocks.delete(idx);
            end else if (pick < 90) begin
                addr = cur_base + 32'($urandom_range(0, cur_region));
            end
        end else if (pick < 94) begin
            req = REQ_INIT;
        end else begin
            req = REQ_NONE;
        end
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        send_request(req, size, addr, 1'b0, '0, ST_OK);
    endtask

    // Result side: random stall bursts, and one long hold on request.
    initial begin
        int hold_left;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (long_hold_ask) begin
                long_hold_ask = 1'b0;
                hold_left     = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end else if (rx_bursty && $urandom_range(0, 7) == 0) begin
                hold_left     = $urandom_range(1, 15) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_grant want;
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                    || i_cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (m_axis_tvalid && m_axis_tready) begin
                status_tally[m_axis_tdata[34:32]]++;
                if (pending_grants.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
                end else begin
                    want = pending_grants.pop_front();
                    if (m_axis_tdata[31:0] !== want.addr)
                        report_mismatch("granted_address", m_axis_tdata[31:0], want.addr);
                    if (m_axis_tdata[34:32] !== want.status)
                        report_mismatch("status", 32'(m_axis_tdata[34:32]), 32'(want.status));
                    if (m_axis_tdata[39:35] !== 5'b0)
                        report_mismatch("padding", 32'(m_axis_tdata[39:35]), '0);
                end
            end
        end
    end

    initial begin
        wait (quiet_cycles >= IDLE_LIMIT);
        $display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
        $display("tb_top NOT OK");
        $finish;
    end

    initial begin
        logic [31:0] base;
        logic [24:0] region;
        logic [16:0] slot;
        int          random_sent;
        int          phase_items;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = CFG_BASE;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = REQ_NONE;
        cur_base      = RST_BASE;
        cur_region    = RST_REGION;
        cur_slot      = RST_SLOT;
        stack_top     = 0;
        slot_count    = 0;
        mismatches    = 0;
        quiet_cycles  = 0;
        phases        = 0;
        gaps_on       = 1'b1;
        rx_bursty     = 1'b1;
        long_hold_ask = 1'b0;
        random_sent   = 0;
        foreach (req_tally[i]) req_tally[i] = 0;
        foreach (status_tally[i]) status_tally[i] = 0;

        // Reset registers: first slot at 0x200010, 4096 slots of 16 bytes, 1024 of
        // them holding the stack itself.
        add_req(REQ_ALLOC, 24'd0,        32'h0020_0008, 1, '0, ST_NO_SLOTS);
        add_req(REQ_FREE,  24'd0,        32'h0020_0008, 1, '0, ST_UNDERFLOW);
        add_req(REQ_FREE,  24'd0,        32'h0020_0000, 1, '0, ST_OUTSIDE);
        add_req(REQ_FREE,  24'd0,        32'h0030_0000, 1, '0, ST_OUTSIDE);
        add_req(REQ_NONE,  24'hFF_FFFF,  32'hFFFF_FFFF, 1, '0, ST_OK);
        add_req(REQ_INIT,  24'd0,        32'h0,         1, '0, ST_OK);
        add_req(REQ_ALLOC, 24'd16,       32'h0,         1, 32'h0020_4010, ST_OK);
        add_req(REQ_ALLOC, 24'd17,       32'h0,         1, '0, ST_TOO_BIG);
        add_req(REQ_ALLOC, 24'hFF_FFFF,  32'h0,         1, '0, ST_TOO_BIG);
        add_req(REQ_FREE,  24'd0,        32'h002F_FFFF, 1, '0, ST_OK);
        add_req(REQ_ALLOC, 24'd1,        32'h0,         1, 32'h002F_FFFF, ST_OK);
        // An address inside the header gives an offset that wraps below zero.
        add_req(REQ_FREE,  24'd0,        32'h0020_0001, 1, '0, ST_OK);
        add_req(REQ_ALLOC, 24'd0,        32'h0,         1, 32'h0020_0001, ST_OK);
        // Region smaller than its header: no slots at all.
        add_cfg(32'h0020_0000, 25'd10, 17'd16);
        add_req(REQ_INIT,  24'd0,        32'h0,         1, '0, ST_OK);
        add_req(REQ_ALLOC, 24'd0,        32'h0,         1, '0, ST_NO_SLOTS);
        add_req(REQ_FREE,  24'd0,        32'h0020_0005, 1, '0, ST_UNDERFLOW);
        // Zero slot size.
        add_cfg(32'h0000_1000, 25'd1000, 17'd0);
        add_req(REQ_INIT,  24'd0,        32'h0,         1, '0, ST_OK);
        add_req(REQ_ALLOC, 24'd0,        32'h0,         1, '0, ST_NO_SLOTS);
        add_req(REQ_ALLOC, 24'd1,        32'h0,         1, '0, ST_TOO_BIG);
        // Slots too small for the stack: the reserve is clamped to the slot count.
        add_cfg(32'h0000_1000, 25'd36, 17'd2);
        add_req(REQ_INIT,  24'd0,        32'h0,         1, '0, ST_OK);
        add_req(REQ_ALLOC, 24'd2,        32'h0,         1, '0, ST_NO_SLOTS);
        add_req(REQ_FREE,  24'd0,        32'h0000_1014, 1, '0, ST_OK);
        // Region at the top of the address space: granted addresses wrap.
        add_cfg(32'hFFFF_FFF0, 25'd80, 17'd8);
        add_req(REQ_INIT,  24'd0,        32'h0,         0, '0, ST_OK);
        add_req(REQ_ALLOC, 24'd8,        32'h0,         0, '0, ST_OK);
        add_req(REQ_FREE,  24'd0,        32'hFFFF_FFFF, 0, '0, ST_OK);
        add_req(REQ_ALLOC, 24'd0,        32'h0,         0, '0, ST_OK);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stimulus_table[i]) begin
            if (stimulus_table[i].kind == ROW_CFG) begin
                settle_block();
                apply_config(stimulus_table[i].base, stimulus_table[i].region,
                             stimulus_table[i].slot);
            end else begin
                send_request(stimulus_table[i].req, stimulus_table[i].size,
                             stimulus_table[i].addr, stimulus_table[i].typed,
                             stimulus_table[i].want_addr, stimulus_table[i].want_status);
            end
        end

        // Each phase: drain, new register values, init, then a random mix.
        for (int phase = 0; random_sent < RANDOM_ITEMS; phase++) begin
            settle_block();
            pick_config(phase, base, region, slot);
            apply_config(base, region, slot);
            if (random_sent >= RANDOM_ITEMS - 120) begin
                gaps_on   = 1'b0;
                rx_bursty = 1'b0;
            end else begin
                gaps_on   = ($urandom_range(0, 3) != 0);
                rx_bursty = ($urandom_range(0, 3) != 0);
            end
            send_request(REQ_INIT, 24'($urandom), $urandom, 1'b0, '0, ST_OK);
            phase_items = $urandom_range(30, 45);
            for (int n = 0; n < phase_items; n++) begin
                // One long stall at the result side while requests keep coming.
                if (phase == 3 && n == 5) long_hold_ask = 1'b1;
                random_item();
                random_sent++;
            end
        end

        s_axis_tvalid <= 1'b0;
        wait (pending_grants.size() == 0);
        repeat (10) @(posedge i_clk);
        $display("Covered %0d requests (%0d allocate, %0d free, %0d init, %0d unused code) over %0d register settings.",
                 req_tally[REQ_ALLOC] + req_tally[REQ_FREE] + req_tally[REQ_INIT]
                 + req_tally[REQ_NONE], req_tally[REQ_ALLOC], req_tally[REQ_FREE],
                 req_tally[REQ_INIT], req_tally[REQ_NONE], phases);
        $display("Results: ok %0d, too big %0d, out of slots %0d, outside %0d, underflow %0d; %0d mismatches.",
                 status_tally[ST_OK], status_tally[ST_TOO_BIG], status_tally[ST_NO_SLOTS],
                 status_tally[ST_OUTSIDE], status_tally[ST_UNDERFLOW], mismatches);
        if (mismatches == 0 && pending_grants.size() == 0) begin
            $display("tb_top OK");
        end else begin
            $display("tb_top NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
sv/fssa_pkg.sv
sv/fssa_div.sv
sv/fssa_dp.sv
sv/fssa_ctrl.sv
sv/fixed_slot_stack_allocator_top.sv
bench/tb_top.sv
